[rtl/fbfla_pkg.sv]
// fbfla_pkg: shared widths, opcode and status codes, register indexes and the
// command/status structs between the allocator controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package fbfla_pkg;

    // pool size default and field widths
    localparam int MAX_BLOCKS_DEF = 255;
    localparam int IDX_W          = 8;
    localparam int OP_W           = 3;
    localparam int STATUS_W       = 3;
    localparam int OFFSET_W       = 24;
    localparam int BSIZE_W        = 16;
    localparam int LINK_W         = 8;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'd1;

    // configuration reset values
    localparam logic [IDX_W-1:0]   NUM_BLOCKS_RST = 8'd255;
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 16'd16;

    // opcodes
    localparam logic [OP_W-1:0] OP_REBUILD = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CORRUPT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic                accept;
        logic                fill_start;
        logic                fill_step;
        logic                fill_done;
        logic                rd_head;
        logic                prod_load;
        logic                alloc_pop;
        logic                rel_push;
        logic                walk_start;
        logic                walk_read;
        logic                walk_load;
        logic                mark;
        logic                vis_clear;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                set_isfree;
        logic                load_out;
    } ctl_cmd_t;

    // datapath to controller status flags
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            deep;
        logic            pool_empty;
        logic            idx_oob;
        logic            total_zero;
        logic            total_gt_p;
        logic            head_oob;
        logic            rel_dup;
        logic            fill_last;
        logic            cur_oob;
        logic            cur_hit;
        logic            walk_end;
        logic            next_oob;
        logic            vis_hit;
        logic            out_free;
    } dp_sts_t;

endpackage

[rtl/fbfla_ram.sv]
// fbfla_ram: generic single-write, single-read RAM with registered read data.
// Depends on fbfla_pkg for default sizes only.
`timescale 1ns / 1ps

module fbfla_ram #(
    parameter int WIDTH = fbfla_pkg::LINK_W,
    parameter int DEPTH = fbfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/fbfla_datapath.sv]
// fbfla_datapath: configuration registers, list head and count, walk cursor,
// visited RAM, offset multiplier, link RAM and result register.
// Depends on fbfla_pkg and fbfla_ram.
`timescale 1ns / 1ps

module fbfla_datapath #(
    parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [fbfla_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                cfg_wr_en,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbfla_pkg::CFG_W-1:0]         cfg_wdata,
    input  fbfla_pkg::ctl_cmd_t                 cmd,
    output fbfla_pkg::dp_sts_t                  sts,
    output logic [fbfla_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready
);

    import fbfla_pkg::*;

    localparam int              AW      = $clog2(MAX_BLOCKS);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BLOCKS);

    logic [IDX_W-1:0]     num_blocks_reg;
    logic [BSIZE_W-1:0]   block_size_reg;
    logic [OP_W-1:0]      op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 deep_reg;
    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     total_reg;
    logic [IDX_W-1:0]     cur_reg;
    logic [IDX_W-1:0]     cc_reg;
    logic [OFFSET_W-1:0]  prod_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [IDX_W-1:0]     res_grant_reg;
    logic [OFFSET_W-1:0]  res_offset_reg;
    logic                 res_isfree_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tvalid_reg;

    logic [IDX_W-1:0]     pool;
    logic [OFFSET_W-1:0]  prod_c;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [LINK_W-1:0]    ram_wr_data;
    logic [AW-1:0]        ram_rd_addr;
    logic [LINK_W-1:0]    ram_rd_data;
    logic                 vis_wr_en;
    logic [AW-1:0]        vis_rd_addr;
    logic [0:0]           vis_rd_data;
    logic [IDX_W-1:0]     cur_inc;

    // pool size in use
    assign pool    = (num_blocks_reg > MAX_IDX) ? MAX_IDX : num_blocks_reg;
    assign cur_inc = IDX_W'(cur_reg + 8'd1);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_blocks_reg <= NUM_BLOCKS_RST;
            block_size_reg <= BLOCK_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NUM_BLOCKS: num_blocks_reg <= cfg_wdata[IDX_W-1:0];
                CFG_BLOCK_SIZE: block_size_reg <= cfg_wdata[BSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // latched request fields
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tdata[OP_W-1:0];
            idx_reg  <= s_tdata[OP_W+IDX_W-1:OP_W];
            deep_reg <= s_tdata[OP_W+IDX_W];
        end
    end

    // free list head and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            total_reg <= '0;
        end else if (cmd.fill_done) begin
            head_reg  <= '0;
            total_reg <= pool;
        end else if (cmd.alloc_pop) begin
            head_reg  <= ram_rd_data;
            total_reg <= IDX_W'(total_reg - 8'd1);
        end else if (cmd.rel_push) begin
            head_reg  <= idx_reg;
            total_reg <= IDX_W'(total_reg + 8'd1);
        end
    end

    // walk cursor, doubling as the rebuild fill and visited clear counter
    always_ff @(posedge aclk) begin
        if (cmd.fill_start) begin
            cur_reg <= '0;
        end else if (cmd.fill_step) begin
            cur_reg <= cur_inc;
        end else if (cmd.walk_start) begin
            cur_reg <= head_reg;
        end else if (cmd.vis_clear) begin
            cur_reg <= cur_inc;
        end else if (cmd.walk_load) begin
            cur_reg <= ram_rd_data;
        end
        if (cmd.walk_start) begin
            cc_reg <= '0;
        end else if (cmd.walk_read) begin
            cc_reg <= IDX_W'(cc_reg + 8'd1);
        end
    end

    // visited RAM: cleared entry by entry before a deep walk, marked at the cursor,
    // looked up at the link just read
    assign vis_wr_en   = cmd.vis_clear | cmd.mark;
    assign vis_rd_addr = ram_rd_data[AW-1:0];

    fbfla_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_vis_ram (
        .aclk    (aclk),
        .wr_en   (vis_wr_en),
        .wr_addr (cur_reg[AW-1:0]),
        .wr_data (cmd.mark),
        .rd_addr (vis_rd_addr),
        .rd_data (vis_rd_data)
    );

    // byte offset multiplier, registered
    assign prod_c = OFFSET_W'(head_reg) * OFFSET_W'(block_size_reg);

    always_ff @(posedge aclk) begin
        if (cmd.prod_load) begin
            prod_reg <= prod_c;
        end
    end

    // result fields for the request in progress
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            res_status_reg <= ST_OK;
            res_grant_reg  <= '0;
            res_offset_reg <= '0;
            res_isfree_reg <= 1'b0;
        end else begin
            if (cmd.set_status) begin
                res_status_reg <= cmd.status;
            end
            if (cmd.set_isfree) begin
                res_isfree_reg <= 1'b1;
            end
            if (cmd.alloc_pop) begin
                res_grant_reg  <= head_reg;
                res_offset_reg <= prod_reg;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {4'd0, total_reg, res_isfree_reg, res_offset_reg,
                            res_grant_reg, res_status_reg};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // link RAM ports
    assign ram_wr_en   = cmd.fill_step | cmd.rel_push;
    assign ram_wr_addr = cmd.fill_step ? cur_reg[AW-1:0] : idx_reg[AW-1:0];
    assign ram_wr_data = cmd.fill_step ? cur_inc : head_reg;
    assign ram_rd_addr = cmd.rd_head ? head_reg[AW-1:0] : cur_reg[AW-1:0];

    fbfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // status flags for the controller
    always_comb begin
        sts            = '0;
        sts.op         = op_reg;
        sts.deep       = deep_reg;
        sts.pool_empty = (pool == '0);
        sts.idx_oob    = (idx_reg >= pool);
        sts.total_zero = (total_reg == '0);
        sts.total_gt_p = (total_reg > pool);
        sts.head_oob   = (head_reg >= pool);
        sts.rel_dup    = ((total_reg != '0) && (head_reg == idx_reg)) || (total_reg >= pool);
        sts.fill_last  = ({1'b0, cur_reg} + 9'd1) >= {1'b0, pool};
        sts.cur_oob    = (cur_reg >= pool);
        sts.cur_hit    = (cur_reg == idx_reg);
        sts.walk_end   = ({1'b0, cc_reg} + 9'd1) >= {1'b0, total_reg};
        sts.next_oob   = (ram_rd_data >= pool);
        sts.vis_hit    = vis_rd_data[0];
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

[rtl/fbfla_ctrl.sv]
// fbfla_ctrl: request sequencer for the allocator; decodes the opcode and
// steps rebuild fills and list walks by commanding the datapath.
// Depends on fbfla_pkg.
`timescale 1ns / 1ps

module fbfla_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fbfla_pkg::dp_sts_t  sts,
    output fbfla_pkg::ctl_cmd_t cmd
);

    import fbfla_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_DECODE  = 12'b0000_0000_0010,
        S_FILL    = 12'b0000_0000_0100,
        S_A_READ  = 12'b0000_0000_1000,
        S_A_POP   = 12'b0000_0001_0000,
        S_Q_TEST  = 12'b0000_0010_0000,
        S_Q_LOAD  = 12'b0000_0100_0000,
        S_C_CLEAR = 12'b0000_1000_0000,
        S_C_MARK  = 12'b0001_0000_0000,
        S_C_LOAD  = 12'b0010_0000_0000,
        S_C_TEST  = 12'b0100_0000_0000,
        S_FINISH  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FINISH;
                unique case (sts.op)
                    OP_REBUILD: begin
                        if (sts.pool_empty) begin
                            cmd.fill_done = 1'b1;
                        end else begin
                            cmd.fill_start = 1'b1;
                            state_next     = S_FILL;
                        end
                    end
                    OP_ALLOC: begin
                        if (sts.total_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end else if (sts.head_oob) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_CORRUPT;
                        end else begin
                            state_next = S_A_READ;
                        end
                    end
                    OP_RELEASE: begin
                        if (sts.idx_oob) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD_INDEX;
                        end else if (sts.rel_dup) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_DOUBLE_FREE;
                        end else begin
                            cmd.rel_push = 1'b1;
                        end
                    end
                    OP_QUERY: begin
                        if (sts.idx_oob) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD_INDEX;
                        end else if (!sts.total_zero) begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_Q_TEST;
                        end
                    end
                    OP_CHECK: begin
                        if (sts.total_gt_p) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_CORRUPT;
                        end else if (sts.total_zero) begin
                            cmd.set_status = 1'b0;
                        end else if (sts.head_oob) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_CORRUPT;
                        end else if (sts.deep) begin
                            cmd.fill_start = 1'b1;
                            state_next     = S_C_CLEAR;
                        end
                    end
                    default: ;
                endcase
            end
            // write one link per cycle, last block links to the pool size
            S_FILL: begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last) begin
                    cmd.fill_done = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_A_READ: begin
                cmd.rd_head   = 1'b1;
                cmd.prod_load = 1'b1;
                state_next    = S_A_POP;
            end
            S_A_POP: begin
                cmd.alloc_pop = 1'b1;
                state_next    = S_FINISH;
            end
            // query walk: test the cursor, then read and load the next link
            S_Q_TEST: begin
                if (sts.cur_oob) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_CORRUPT;
                    state_next     = S_FINISH;
                end else if (sts.cur_hit) begin
                    cmd.set_isfree = 1'b1;
                    state_next     = S_FINISH;
                end else if (sts.walk_end) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.walk_read = 1'b1;
                    state_next    = S_Q_LOAD;
                end
            end
            S_Q_LOAD: begin
                cmd.walk_load = 1'b1;
                state_next    = S_Q_TEST;
            end
            // clear one visited entry per cycle over the pool, then start the walk
            S_C_CLEAR: begin
                cmd.vis_clear = 1'b1;
                if (sts.fill_last) begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_C_MARK;
                end
            end
            // deep check walk with visited marks: mark, read and load the next link, then test it
            S_C_MARK: begin
                cmd.mark = 1'b1;
                if (sts.walk_end) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.walk_read = 1'b1;
                    state_next    = S_C_LOAD;
                end
            end
            S_C_LOAD: begin
                if (sts.next_oob) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_CORRUPT;
                    state_next     = S_FINISH;
                end else begin
                    cmd.walk_load = 1'b1;
                    state_next    = S_C_TEST;
                end
            end
            S_C_TEST: begin
                if (sts.vis_hit) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_CORRUPT;
                    state_next     = S_FINISH;
                end else begin
                    state_next = S_C_MARK;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/fixed_block_free_list_allocator.sv]
// Channel   Dir  Handshake           Payload
// request   in   s_tvalid/s_tready   s_tdata: opcode, block_index, deep_check
// result    out  m_tvalid/m_tready   m_tdata: status, granted_index, byte_offset,
//                                             is_free, free_count
// config    in   cfg_wr_en           cfg_index, cfg_wdata (num_blocks, block_size)
//
// One request at a time: each is accepted, decoded, worked on and then loaded into
// the result register. Rebuild does one link RAM write per block. Query walks the
// list through the link RAM's registered read port. Deep check first clears the
// visited RAM over the whole pool, then walks the list, marking each block it visits.
// Synchronous active-low reset; the link and visited RAMs are not cleared. A result
// waiting on m_tready does not stop the next request from being taken and worked on.
// Depends on fbfla_pkg, fbfla_ctrl, fbfla_datapath, fbfla_ram.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // opcode [2:0], block_index [10:3], deep_check [11], zero [15:12]
    input  logic [fbfla_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // status [2:0], granted_index [10:3], byte_offset [34:11], is_free [35],
    // free_count [43:36], zero [47:44]
    output logic [fbfla_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbfla_pkg::CFG_W-1:0]     cfg_wdata
);

    import fbfla_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // request sequencer
    fbfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // list state, link RAM and result register
    fbfla_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule
